>>> src/rrq_pkg.sv
// Shared constants, types and helper functions for the rotation-rows-to-quaternion block.
// Used by the square-root pipeline and the top level; depends on nothing.
package rrq_pkg;

  localparam int IN_FRAC_BITS_DEF = 16;
  localparam logic [16:0] MIN_ROW_NORM_RST = 17'd7;
  localparam int SQRT_STAGES = 32;

  localparam logic signed [34:0] Q30_ONE = 35'sh0_4000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  localparam logic [1:0] BR_W = 2'd0;
  localparam logic [1:0] BR_X = 2'd1;
  localparam logic [1:0] BR_Y = 2'd2;
  localparam logic [1:0] BR_Z = 2'd3;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_stage_t;

  function automatic sqrt_stage_t sqrt_step(sqrt_stage_t x, int s);
    logic [63:0] b;
    logic [63:0] trial;
    sqrt_stage_t y;
    b = 64'd1 << (62 - 2 * s);
    trial = x.root + b;
    if (x.rem >= trial) begin
      y.rem = x.rem - trial;
      y.root = (x.root >> 1) + b;
    end else begin
      y.rem = x.rem;
      y.root = x.root >> 1;
    end
    return y;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < 64'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/rrq_if.sv
// Channel interfaces of the block: matrix rows in, quaternion out, and the register write port.
// Standalone; no package needed.
interface rrq_rows_if;
  logic valid;
  logic ready;
  logic signed [31:0] row0_x;
  logic signed [31:0] row0_y;
  logic signed [31:0] row0_z;
  logic signed [31:0] row1_x;
  logic signed [31:0] row1_y;
  logic signed [31:0] row1_z;
  logic signed [31:0] row2_x;
  logic signed [31:0] row2_y;
  logic signed [31:0] row2_z;
  modport source(output valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
                 row2_x, row2_y, row2_z, input ready);
  modport sink(input valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
               row2_x, row2_y, row2_z, output ready);
endinterface

interface rrq_quat_if;
  logic valid;
  logic ready;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] quat_w;
  modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface rrq_cfg_if;
  logic valid;
  logic ready;
  logic [16:0] min_row_norm;
  modport source(output valid, min_row_norm, input ready);
  modport sink(input valid, min_row_norm, output ready);
endinterface

>>> src/rrq_sqrt.sv
// Pipelined integer square root of 64-bit radicands, one result bit per register stage.
// Depends on rrq_pkg for the stage count and the step function.
module rrq_sqrt #(
  parameter int LANES = 1,
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [LANES-1:0][63:0]  rad,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  output logic [LANES-1:0][31:0]  root,
  output logic [SIDE_W-1:0]       out_side
);

  localparam int STG = rrq_pkg::SQRT_STAGES;

  rrq_pkg::sqrt_stage_t [LANES-1:0] stg_q [STG];
  logic [SIDE_W-1:0] side_q [STG];
  logic [STG-1:0] vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= in_side;
      for (int l = 0; l < LANES; l++) begin
        stg_q[0][l] <= rrq_pkg::sqrt_step('{rem: rad[l], root: 64'd0}, 0);
      end
      for (int s = 1; s < STG; s++) begin
        side_q[s] <= side_q[s-1];
        for (int l = 0; l < LANES; l++) begin
          stg_q[s][l] <= rrq_pkg::sqrt_step(stg_q[s-1][l], s);
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root[l] = stg_q[STG-1][l].root[31:0];
    end
  end

  assign out_valid = vld_q[STG-1];
  assign out_side = side_q[STG-1];

endmodule

>>> src/rrq_div.sv
// Pipelined restoring divider, one quotient bit per register stage, several lanes in step.
// Standalone; the caller keeps the high numerator part below the divisor or discards the result.
module rrq_div #(
  parameter int LANES = 1,
  parameter int DW = 32,
  parameter int QW = 31,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][DW+QW-1:0] num,
  input  logic [LANES-1:0][DW-1:0]   den,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   quo,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int NW = DW + QW;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] lo;
    logic [QW-1:0] q;
    logic [DW-1:0] den;
  } div_stage_t;

  function automatic div_stage_t div_step(div_stage_t x);
    logic [DW:0] trial;
    logic ge;
    div_stage_t y;
    trial = {x.rem, x.lo[QW-1]};
    ge = trial >= {1'b0, x.den};
    y = x;
    y.rem = ge ? DW'(trial - {1'b0, x.den}) : DW'(trial);
    y.lo = x.lo << 1;
    y.q = {x.q[QW-2:0], ge};
    return y;
  endfunction

  div_stage_t [LANES-1:0] stg_q [QW];
  logic [SIDE_W-1:0] side_q [QW];
  logic [QW-1:0] vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= in_side;
      for (int l = 0; l < LANES; l++) begin
        stg_q[0][l] <= div_step('{rem: num[l][NW-1:QW], lo: num[l][QW-1:0],
                                  q: '0, den: den[l]});
      end
      for (int s = 1; s < QW; s++) begin
        side_q[s] <= side_q[s-1];
        for (int l = 0; l < LANES; l++) begin
          stg_q[s][l] <= div_step(stg_q[s-1][l]);
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = stg_q[QW-1][l].q;
    end
  end

  assign out_valid = vld_q[QW-1];
  assign out_side = side_q[QW-1];

endmodule

>>> src/rotation_rows_to_quaternion.sv
// Converts the three rows of a row-vector rotation matrix into an xyzw quaternion in Q2.30.
// Depends on rrq_pkg, the channel interfaces in rrq_if, rrq_sqrt and rrq_div.
//
// The rows channel takes one matrix per transfer, nine signed fixed-point elements with
// IN_FRAC_BITS fraction bits. The quat channel gives one quaternion per matrix, in order.
// The cfg channel writes min_row_norm and is always ready; write it only while idle.
// Each row is scaled to unit length unless its length is zero or below min_row_norm; the matrix
// is then read transposed and the trace or the largest diagonal picks the root branch.
// The block takes one matrix every cycle unless the pipeline holds, as said below. The
// pipeline holds the two 32-stage square roots and the two dividers (31 and 32 stages),
// each producing one bit per register stage.
// All stages advance together; while quat.valid is high and quat.ready is low the whole
// pipeline holds, and rows.ready drops, so nothing is lost or repeated.
// Reset clears every valid bit and sets min_row_norm to 7; payload registers keep
// whatever they held.
module rotation_rows_to_quaternion #(
  parameter int IN_FRAC_BITS = rrq_pkg::IN_FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  rrq_rows_if.sink  rows,
  rrq_cfg_if.sink   cfg,
  rrq_quat_if.source quat
);

  localparam int SH = 30 - IN_FRAC_BITS;

  logic en;
  logic out_valid;
  logic [16:0] min_norm;

  assign en = ~out_valid | quat.ready;
  assign rows.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_norm <= rrq_pkg::MIN_ROW_NORM_RST;
    end else if (cfg.valid) begin
      min_norm <= cfg.min_row_norm;
    end
  end

  // Magnitudes, squares and row sums.
  logic [8:0][31:0] e_in;
  assign e_in[0] = rows.row0_x;
  assign e_in[1] = rows.row0_y;
  assign e_in[2] = rows.row0_z;
  assign e_in[3] = rows.row1_x;
  assign e_in[4] = rows.row1_y;
  assign e_in[5] = rows.row1_z;
  assign e_in[6] = rows.row2_x;
  assign e_in[7] = rows.row2_y;
  assign e_in[8] = rows.row2_z;

  logic v1, v2, v3;
  logic [8:0][31:0] e1, mag1, e2, e3;
  logic [8:0][63:0] sq2;
  logic [2:0][63:0] ss3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= rows.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        e1[k] <= e_in[k];
        mag1[k] <= e_in[k][31] ? (~e_in[k] + 32'd1) : e_in[k];
        e2[k] <= e1[k];
        sq2[k] <= 64'(mag1[k]) * 64'(mag1[k]);
      end
      e3 <= e2;
      for (int i = 0; i < 3; i++) begin
        ss3[i] <= sq2[3*i] + sq2[3*i+1] + sq2[3*i+2];
      end
    end
  end

  // Row lengths.
  logic v4;
  logic [2:0][31:0] n4;
  logic [8:0][31:0] e4;

  rrq_sqrt #(.LANES(3), .SIDE_W(288)) u_row_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .rad(ss3), .in_side(e3),
    .out_valid(v4), .root(n4), .out_side(e4)
  );

  logic v5;
  logic [8:0][31:0] e5, mag5;
  logic [2:0][31:0] n5;
  logic [2:0] short5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e5 <= e4;
      for (int k = 0; k < 9; k++) begin
        mag5[k] <= e4[k][31] ? (~e4[k] + 32'd1) : e4[k];
      end
      for (int i = 0; i < 3; i++) begin
        n5[i] <= n4[i];
        short5[i] <= (n4[i] == 32'd0) || (n4[i] < 32'(min_norm));
      end
    end
  end

  // Row normalization: round(|e| * 2^30 / n).
  logic [8:0][62:0] rnum;
  logic [8:0][31:0] rden;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rnum[3*i+j] = 63'({mag5[3*i+j], 30'd0}) + 63'(n5[i][31:1]);
        rden[3*i+j] = n5[i];
      end
    end
  end

  logic v6;
  logic [8:0][30:0] q6;
  logic [290:0] rside6;
  logic [2:0] short6;
  logic [8:0][31:0] e6;

  rrq_div #(.LANES(9), .DW(32), .QW(31), .SIDE_W(291)) u_row_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v5), .num(rnum), .den(rden), .in_side({short5, e5}),
    .out_valid(v6), .quo(q6), .out_side(rside6)
  );

  assign short6 = rside6[290:288];
  assign e6 = rside6[287:0];

  logic va;
  logic signed [31:0] a_r [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (short6[i]) begin
            a_r[3*i+j] <= rrq_pkg::sat32(64'(signed'(e6[3*i+j])) <<< SH);
          end else if (e6[3*i+j][31]) begin
            a_r[3*i+j] <= 32'd0 - 32'(q6[3*i+j]);
          end else begin
            a_r[3*i+j] <= 32'(q6[3*i+j]);
          end
        end
      end
    end
  end

  // Branch selection on the transposed matrix.
  logic signed [33:0] tr_a;
  logic [1:0] br_a;

  always_comb begin
    tr_a = 34'(a_r[0]) + 34'(a_r[4]) + 34'(a_r[8]);
    if (tr_a > 34'sd0) begin
      br_a = rrq_pkg::BR_W;
    end else if (a_r[0] > a_r[4] && a_r[0] > a_r[8]) begin
      br_a = rrq_pkg::BR_X;
    end else if (a_r[4] > a_r[8]) begin
      br_a = rrq_pkg::BR_Y;
    end else begin
      br_a = rrq_pkg::BR_Z;
    end
  end

  logic vb;
  logic signed [31:0] b_a [9];
  logic signed [33:0] tr_b;
  logic [1:0] br_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_a <= a_r;
      tr_b <= tr_a;
      br_b <= br_a;
    end
  end

  // Radicand and numerators; the numerators are ordered by their output slot.
  logic signed [34:0] t_b;
  logic signed [33:0] num_b [3];

  always_comb begin
    case (br_b)
      rrq_pkg::BR_W: begin
        t_b = 35'(tr_b) + rrq_pkg::Q30_ONE;
        num_b[0] = 34'(b_a[5]) - 34'(b_a[7]);
        num_b[1] = 34'(b_a[6]) - 34'(b_a[2]);
        num_b[2] = 34'(b_a[1]) - 34'(b_a[3]);
      end
      rrq_pkg::BR_X: begin
        t_b = rrq_pkg::Q30_ONE + 35'(b_a[0]) - 35'(b_a[4]) - 35'(b_a[8]);
        num_b[0] = 34'(b_a[1]) + 34'(b_a[3]);
        num_b[1] = 34'(b_a[2]) + 34'(b_a[6]);
        num_b[2] = 34'(b_a[5]) - 34'(b_a[7]);
      end
      rrq_pkg::BR_Y: begin
        t_b = rrq_pkg::Q30_ONE + 35'(b_a[4]) - 35'(b_a[0]) - 35'(b_a[8]);
        num_b[0] = 34'(b_a[1]) + 34'(b_a[3]);
        num_b[1] = 34'(b_a[5]) + 34'(b_a[7]);
        num_b[2] = 34'(b_a[6]) - 34'(b_a[2]);
      end
      default: begin
        t_b = rrq_pkg::Q30_ONE + 35'(b_a[8]) - 35'(b_a[0]) - 35'(b_a[4]);
        num_b[0] = 34'(b_a[2]) + 34'(b_a[6]);
        num_b[1] = 34'(b_a[5]) + 34'(b_a[7]);
        num_b[2] = 34'(b_a[1]) - 34'(b_a[3]);
      end
    endcase
  end

  logic vc;
  logic signed [34:0] t_c;
  logic signed [33:0] num_c [3];
  logic [1:0] br_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_c <= t_b;
      num_c <= num_b;
      br_c <= br_b;
    end
  end

  // A negative radicand is taken as zero.
  logic [0:0][63:0] qrad;
  assign qrad[0] = (t_c <= 35'sd0) ? 64'd0 : (64'(t_c) << 30);

  logic vd;
  logic [0:0][31:0] r_d;
  logic [103:0] side_d;
  logic [1:0] br_d;
  logic signed [33:0] num_d [3];

  rrq_sqrt #(.LANES(1), .SIDE_W(104)) u_quat_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vc), .rad(qrad), .in_side({br_c, num_c[0], num_c[1], num_c[2]}),
    .out_valid(vd), .root(r_d), .out_side(side_d)
  );

  assign br_d = side_d[103:102];
  assign num_d[0] = side_d[101:68];
  assign num_d[1] = side_d[67:34];
  assign num_d[2] = side_d[33:0];

  logic ve;
  logic [2:0][64:0] nq_e;
  logic [32:0] d_e;
  logic [31:0] r_e;
  logic [1:0] br_e;
  logic [2:0] neg_e, zero_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        nq_e[k] <= (65'(num_d[k][33] ? 34'(-num_d[k]) : 34'(num_d[k])) << 30)
                   + 65'(r_d[0]);
        neg_e[k] <= num_d[k][33];
        zero_e[k] <= (num_d[k] == 34'sd0);
      end
      d_e <= {r_d[0], 1'b0};
      r_e <= r_d[0];
      br_e <= br_d;
    end
  end

  // A quotient of 2^32 or more only ever saturates, so it is flagged up front.
  logic [2:0] ovf_e;
  logic [2:0][32:0] qden;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ovf_e[k] = nq_e[k][64:32] >= d_e;
      qden[k] = d_e;
    end
  end

  logic vf;
  logic [2:0][31:0] q_f;
  logic [42:0] side_f;
  logic [1:0] br_f;
  logic [31:0] r_f;
  logic [2:0] neg_f, zero_f, ovf_f;

  rrq_div #(.LANES(3), .DW(33), .QW(32), .SIDE_W(43)) u_quat_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(ve), .num(nq_e), .den(qden),
    .in_side({br_e, r_e, neg_e, zero_e, ovf_e}),
    .out_valid(vf), .quo(q_f), .out_side(side_f)
  );

  assign br_f = side_f[42:41];
  assign r_f = side_f[40:9];
  assign neg_f = side_f[8:6];
  assign zero_f = side_f[5:3];
  assign ovf_f = side_f[2:0];

  function automatic logic signed [31:0] div_final(logic [31:0] q, logic neg, logic zero,
                                                   logic ovf);
    logic signed [31:0] r;
    if (zero) begin
      r = 32'sd0;
    end else if (neg) begin
      r = (ovf || q[31]) ? rrq_pkg::S32_MIN : signed'(32'd0 - q);
    end else begin
      r = (ovf || q[31]) ? rrq_pkg::S32_MAX : signed'(q);
    end
    return r;
  endfunction

  logic signed [31:0] o_f [3];
  logic [32:0] half_f;
  logic signed [31:0] hs_f;
  logic signed [31:0] qx_n, qy_n, qz_n, qw_n;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      o_f[k] = div_final(q_f[k], neg_f[k], zero_f[k], ovf_f[k]);
    end
    half_f = (33'(r_f) + 33'd1) >> 1;
    hs_f = half_f[31] ? rrq_pkg::S32_MAX : signed'(half_f[31:0]);
    case (br_f)
      rrq_pkg::BR_W: begin
        qx_n = o_f[0];
        qy_n = o_f[1];
        qz_n = o_f[2];
        qw_n = hs_f;
      end
      rrq_pkg::BR_X: begin
        qx_n = hs_f;
        qy_n = o_f[0];
        qz_n = o_f[1];
        qw_n = o_f[2];
      end
      rrq_pkg::BR_Y: begin
        qx_n = o_f[0];
        qy_n = hs_f;
        qz_n = o_f[1];
        qw_n = o_f[2];
      end
      default: begin
        qx_n = o_f[0];
        qy_n = o_f[1];
        qz_n = hs_f;
        qw_n = o_f[2];
      end
    endcase
  end

  logic signed [31:0] qx_r, qy_r, qz_r, qw_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r <= qx_n;
      qy_r <= qy_n;
      qz_r <= qz_n;
      qw_r <= qw_n;
    end
  end

  assign quat.valid = out_valid;
  assign quat.quat_x = qx_r;
  assign quat.quat_y = qy_r;
  assign quat.quat_z = qz_r;
  assign quat.quat_w = qw_r;

endmodule

>>> bench/rotation_rows_to_quaternion_test.sv
// Self-checking bench for rotation_rows_to_quaternion: matrices in, Q2.30 quaternions out.
// Depends on rrq_pkg, the channel interfaces in rrq_if and the block's RTL.
`timescale 1ns / 100ps

module rotation_rows_to_quaternion_test;

  localparam int FRAC = rrq_pkg::IN_FRAC_BITS_DEF;
  localparam int LATENCY = 136;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 800;

  typedef logic signed [31:0] elem_t;
  typedef struct {
    elem_t e [9];
  } matrix_t;
  typedef struct packed {
    elem_t x, y, z, w;
  } quat_t;
  typedef struct {
    matrix_t m;
    bit known;
    quat_t q;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rrq_rows_if rows ();
  rrq_quat_if quat ();
  rrq_cfg_if cfg ();

  rotation_rows_to_quaternion dut (
    .clk(clk),
    .rst(rst),
    .rows(rows.sink),
    .cfg(cfg.sink),
    .quat(quat.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [16:0] row_norm_floor;
  quat_t expected_quats [$];
  vector_t vectors [$];
  int errors = 0;
  int quats_seen = 0;
  int matrices_sent = 0;
  int idle_cycles = 0;
  bit stall_sink = 1'b1;
  bit calm = 1'b0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scaled_div(longint num, logic [63:0] den);
    logic [63:0] m;
    logic [63:0] q;
    m = num < 0 ? -num : num;
    if (den == 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
    q = ((m << 30) + den / 2) / den;
    if (q > (64'd1 << 32)) q = 64'd1 << 32;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [63:0] q30_root(longint t);
    if (t <= 0) return 0;
    return isqrt(64'(t) << 30);
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t mx, logic [16:0] floor_norm);
    longint a [3][3];
    longint m [3][3];
    longint q [4];
    longint e;
    longint tr;
    logic [63:0] ss, n, r, d, mg;
    quat_t res;
    for (int i = 0; i < 3; i++) begin
      ss = 0;
      for (int j = 0; j < 3; j++) begin
        e = mx.e[i * 3 + j];
        mg = e < 0 ? -e : e;
        ss += mg * mg;
      end
      n = isqrt(ss);
      for (int j = 0; j < 3; j++) begin
        e = mx.e[i * 3 + j];
        if (n == 0 || n < floor_norm) a[i][j] = clamp32(e * (64'sd1 << (30 - FRAC)));
        else a[i][j] = scaled_div(e, n);
      end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = a[j][i];
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      r = q30_root(tr + (64'sd1 << 30));
      d = 2 * r;
      q[3] = (r + 1) >> 1;
      q[0] = scaled_div(m[2][1] - m[1][2], d);
      q[1] = scaled_div(m[0][2] - m[2][0], d);
      q[2] = scaled_div(m[1][0] - m[0][1], d);
    end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
      r = q30_root((64'sd1 << 30) + m[0][0] - m[1][1] - m[2][2]);
      d = 2 * r;
      q[3] = scaled_div(m[2][1] - m[1][2], d);
      q[0] = (r + 1) >> 1;
      q[1] = scaled_div(m[0][1] + m[1][0], d);
      q[2] = scaled_div(m[0][2] + m[2][0], d);
    end else if (m[1][1] > m[2][2]) begin
      r = q30_root((64'sd1 << 30) + m[1][1] - m[0][0] - m[2][2]);
      d = 2 * r;
      q[3] = scaled_div(m[0][2] - m[2][0], d);
      q[0] = scaled_div(m[0][1] + m[1][0], d);
      q[1] = (r + 1) >> 1;
      q[2] = scaled_div(m[1][2] + m[2][1], d);
    end else begin
      r = q30_root((64'sd1 << 30) + m[2][2] - m[0][0] - m[1][1]);
      d = 2 * r;
      q[3] = scaled_div(m[1][0] - m[0][1], d);
      q[0] = scaled_div(m[0][2] + m[2][0], d);
      q[1] = scaled_div(m[1][2] + m[2][1], d);
      q[2] = (r + 1) >> 1;
    end
    res.x = clamp32(q[0]);
    res.y = clamp32(q[1]);
    res.z = clamp32(q[2]);
    res.w = clamp32(q[3]);
    return res;
  endfunction

  task automatic report_mismatch(string field, elem_t got, elem_t want);
    $display("mismatch on quaternion %0d, %s: got %0d, expected %0d",
             quats_seen, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ((rows.valid && rows.ready) || (quat.valid && quat.ready) ||
          (cfg.valid && cfg.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("rotation_rows_to_quaternion_test: FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    quat_t want;
    if (rst) begin
      quat.ready <= 1'b0;
    end else begin
      if (quat.valid && quat.ready) begin
        if (expected_quats.size() == 0) begin
          $display("unexpected quaternion %0d", quats_seen);
          errors++;
        end else begin
          want = expected_quats.pop_front();
          if (quat.quat_x !== want.x) report_mismatch("x", quat.quat_x, want.x);
          if (quat.quat_y !== want.y) report_mismatch("y", quat.quat_y, want.y);
          if (quat.quat_z !== want.z) report_mismatch("z", quat.quat_z, want.z);
          if (quat.quat_w !== want.w) report_mismatch("w", quat.quat_w, want.w);
        end
        quats_seen++;
      end
      if (calm) quat.ready <= 1'b1;
      else if (stall_sink) quat.ready <= 1'b0;
      else quat.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && !calm) begin
      stall_sink <= $urandom_range(0, 1);
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  end

  task automatic write_floor(logic [16:0] v);
    cfg.valid <= 1'b1;
    cfg.min_row_norm <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    row_norm_floor = v;
  endtask

  task automatic drain();
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic send_matrix(matrix_t mx);
    if (!calm && $urandom_range(0, 7) == 0) begin
      rows.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    rows.valid <= 1'b1;
    rows.row0_x <= mx.e[0]; rows.row0_y <= mx.e[1]; rows.row0_z <= mx.e[2];
    rows.row1_x <= mx.e[3]; rows.row1_y <= mx.e[4]; rows.row1_z <= mx.e[5];
    rows.row2_x <= mx.e[6]; rows.row2_y <= mx.e[7]; rows.row2_z <= mx.e[8];
    @(posedge clk);
    while (!rows.ready) @(posedge clk);
    expected_quats.push_back(matrix_to_quat(mx, row_norm_floor));
    matrices_sent++;
  endtask

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 * (1 << FRAC))) - (1 << FRAC);
      default: return $signed($urandom_range(0, 64)) - 32;
    endcase
  endfunction

  function automatic matrix_t rotation(int axis, int c, int s);
    matrix_t mx;
    for (int i = 0; i < 9; i++) mx.e[i] = 0;
    case (axis)
      0: begin
        mx.e[0] = 1 << FRAC; mx.e[4] = c; mx.e[5] = s; mx.e[7] = -s; mx.e[8] = c;
      end
      1: begin
        mx.e[4] = 1 << FRAC; mx.e[0] = c; mx.e[2] = -s; mx.e[6] = s; mx.e[8] = c;
      end
      default: begin
        mx.e[8] = 1 << FRAC; mx.e[0] = c; mx.e[1] = s; mx.e[3] = -s; mx.e[4] = c;
      end
    endcase
    return mx;
  endfunction

  function automatic vector_t row(elem_t e0, elem_t e1, elem_t e2, elem_t e3, elem_t e4,
                                  elem_t e5, elem_t e6, elem_t e7, elem_t e8,
                                  bit known, elem_t qx, elem_t qy, elem_t qz, elem_t qw);
    vector_t v;
    v.m.e = '{e0, e1, e2, e3, e4, e5, e6, e7, e8};
    v.known = known;
    v.q.x = qx; v.q.y = qy; v.q.z = qz; v.q.w = qw;
    return v;
  endfunction

  initial begin
    localparam elem_t ONE = 1 << FRAC;
    localparam elem_t MX = 32'sh7fff_ffff;
    localparam elem_t MN = 32'sh8000_0000;
    localparam elem_t QH = 32'sh2000_0000;
    localparam elem_t QO = 32'sh4000_0000;
    matrix_t mx;
    int mode;
    rows.valid = 1'b0;
    rows.row0_x = 0; rows.row0_y = 0; rows.row0_z = 0;
    rows.row1_x = 0; rows.row1_y = 0; rows.row1_z = 0;
    rows.row2_x = 0; rows.row2_y = 0; rows.row2_z = 0;
    cfg.valid = 1'b0;
    cfg.min_row_norm = rrq_pkg::MIN_ROW_NORM_RST;
    row_norm_floor = rrq_pkg::MIN_ROW_NORM_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity gives the unit scalar; the zero matrix falls to the z branch with a root of one.
    vectors.push_back(row(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1, 0, 0, 0, QO));
    vectors.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, QH, 0));
    // Half turns about each axis exercise the x, y and z branches.
    vectors.push_back(row(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, 1, QO, 0, 0, 0));
    vectors.push_back(row(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE, 1, 0, QO, 0, 0));
    vectors.push_back(row(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE, 1, 0, 0, QO, 0));
    // Negative identity: the diagonal ties, so it falls to the z branch with a radicand of two.
    vectors.push_back(row(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, 0, 0, 0, 0, 0));
    vectors.push_back(row(MX, MX, MX, MN, MN, MN, MX, MN, MX, 0, 0, 0, 0, 0));
    vectors.push_back(row(MN, 0, 0, 0, MN, 0, 0, 0, MN, 0, 0, 0, 0, 0));
    vectors.push_back(row(MX, 0, 0, 0, MX, 0, 0, 0, MX, 1, 0, 0, 0, QO));
    vectors.push_back(row(3, 0, 0, 0, 3, 0, 0, 0, 3, 0, 0, 0, 0, 0));
    vectors.push_back(row(-1, 5, 2, 6, -3, 0, 0, 1, -6, 0, 0, 0, 0, 0));
    vectors.push_back(row(0, ONE, 0, ONE, 0, 0, 0, 0, -ONE, 0, 0, 0, 0, 0));
    vectors.push_back(row(46341, 46341, 0, -46341, 46341, 0, 0, 0, ONE, 0, 0, 0, 0, 0));
    vectors.push_back(row(ONE, 2, -ONE, 7, 7, 7, MN, 1, 0, 0, 0, 0, 0, 0));
    foreach (vectors[i]) begin
      if (vectors[i].known) begin
        if (matrix_to_quat(vectors[i].m, row_norm_floor) != vectors[i].q)
          $display("table row %0d disagrees with the predictor", i);
        send_matrix(vectors[i].m);
        expected_quats[$] = vectors[i].q;
      end else begin
        send_matrix(vectors[i].m);
      end
    end
    rows.valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_floor(17'd0);
        1: write_floor(17'h1ffff);
        2: write_floor(17'd65536);
        3: write_floor($urandom_range(0, 70000));
        default: write_floor(rrq_pkg::MIN_ROW_NORM_RST);
      endcase
      if (phase == 4) calm = 1'b1;
      for (int k = 0; k < RANDOM_ITEMS / 5; k++) begin
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
          mx = rotation($urandom_range(0, 2), rand_elem(1), rand_elem(1));
          if (mode == 0) for (int i = 0; i < 9; i++) mx.e[i] = mx.e[i] * 3 + rand_elem(2);
        end else begin
          for (int i = 0; i < 9; i++) mx.e[i] = rand_elem(mode < 8 ? 1 : (mode == 8 ? 0 : 2));
        end
        send_matrix(mx);
      end
      rows.valid <= 1'b0;
      drain();
    end

    $display("sent %0d matrices over five settings of the row-length floor", matrices_sent);
    $display("checked %0d quaternions, %0d mismatches", quats_seen, errors);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("rotation_rows_to_quaternion_test: PASS");
    end else begin
      $display("rotation_rows_to_quaternion_test: FAIL");
    end
    $finish;
  end

endmodule
